@@ design/bump_allocator_with_free_list_macros.svh @@
// Assertion macros for the allocator
`ifndef BUMP_ALLOCATOR_WITH_FREE_LIST_MACROS_SVH
`define BUMP_ALLOCATOR_WITH_FREE_LIST_MACROS_SVH
`ifndef SYNTH
`define BA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define BA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BA_ASSERT(lbl, clk, rst_n, prop)
`define BA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ design/bafl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bafl_pkg;
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 33;
    localparam int REQ_W  = 32;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_BAD_FREE  = 3'd3;
    localparam logic [2:0] ST_LIST_FULL = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [0:0] REG_HEAP_BASE  = 1'b0;
    localparam logic [0:0] REG_HEAP_BYTES = 1'b1;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 48'h0600_0000_0000;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = 33'h1_0000_0000;

    // cell control: clear, shift-left from a match point, or append at the tail
    typedef struct packed {
        logic                  clear;
        logic                  remove;
        logic                  append;
        logic [SIZE_W-1:0]     size;
        logic [ADDR_W-1:0]     addr;
        logic [3:0]            align;
    } t_cell_ctl;
endpackage
`default_nettype wire

@@ design/bafl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One free-list slot. Holds an entry, compares against the request, and
// shifts in its right neighbor's entry when a slot at or left of it is removed.
module bafl_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bafl_pkg::t_cell_ctl         i_ctl,
    input  wire logic                        i_is_tail,   // slot index == count
    input  wire logic                        i_remove_here_or_left,
    input  wire logic                        i_nb_valid,
    input  wire logic [bafl_pkg::SIZE_W-1:0] i_nb_size,
    input  wire logic [bafl_pkg::ADDR_W-1:0] i_nb_addr,
    output logic                             o_valid,
    output logic [bafl_pkg::SIZE_W-1:0]      o_size,
    output logic [bafl_pkg::ADDR_W-1:0]      o_addr,
    output logic                             o_match
);
    import bafl_pkg::*;
    logic [ADDR_W-1:0] w_mask;

    always_comb begin
        w_mask  = (ADDR_W'(1) << i_ctl.align) - ADDR_W'(1);
        o_match = o_valid && (o_size == i_ctl.size) && ((o_addr & w_mask) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            o_valid <= 1'b0;
        end else if (i_ctl.remove && i_remove_here_or_left) begin
            o_valid <= i_nb_valid;
            o_size  <= i_nb_size;
            o_addr  <= i_nb_addr;
        end else if (i_ctl.append && i_is_tail) begin
            o_valid <= 1'b1;
            o_size  <= i_ctl.size;
            o_addr  <= i_ctl.addr;
        end
    end
endmodule
`default_nettype wire

@@ design/bump_allocator_with_free_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid/tready     tdata: opcode, req_size, align_log2, free_address
// m_axis    out  tvalid/tready     tdata: block_address, status, reused
// cfg       in   valid/ready       index (0 heap_base, 1 heap_bytes), data
//
// Each transaction passes through accept, compare across the cell row
// (oldest match by priority select), bump align/limit check, then the result
// register. The free list is a row of FREE_ENTRIES cells; removal shifts
// every cell above the match left by one, all cells at once.
// Synchronous active-low reset empties the list and loads the reset base.
// The next transaction is accepted once the result register is empty.
module bump_allocator_with_free_list #(
    parameter int FREE_ENTRIES = 64,
    parameter int MIN_ALIGN    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] opcode, [32:1] req_size, [36:33] align_log2, [84:37] free_address
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [47:0] block_address, [50:48] status, [51] reused
    output logic [55:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);
    import bafl_pkg::*;
    localparam int IDX_W = $clog2(FREE_ENTRIES);
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_BUMP, S_OUT} t_state;
    t_state r_state;

    logic [ADDR_W-1:0] r_base, r_next;
    logic [SIZE_W-1:0] r_bytes;
    logic [CNT_W-1:0]  r_count;
    logic              r_op;
    logic [SIZE_W-1:0] r_size;
    logic [3:0]        r_align;
    logic [ADDR_W-1:0] r_fa;
    logic              r_found;
    logic [ADDR_W-1:0] r_hit_addr;
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W:0]   r_end;
    logic [ADDR_W-1:0] r_out_addr;
    logic [2:0]        r_out_st;
    logic              r_out_reused;
    logic [IDX_W-1:0]  r_hit_idx;

    t_cell_ctl         w_ctl;
    logic [FREE_ENTRIES-1:0] w_valid, w_match, w_rm;
    logic [SIZE_W-1:0] w_csize [FREE_ENTRIES];
    logic [ADDR_W-1:0] w_caddr [FREE_ENTRIES];
    logic              w_any;
    logic [IDX_W-1:0]  w_idx;
    logic [ADDR_W-1:0] w_haddr;

    logic [ADDR_W+1:0] w_round;
    logic [SIZE_W-1:0] n_size;
    logic [ADDR_W:0]   w_limit;
    logic [ADDR_W:0]   w_eff;
    logic [ADDR_W+1:0] w_st;
    logic [ADDR_W+1:0] w_fend;

    logic w_cfg_wr, w_in_acc, w_rm_go, w_app_go;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_out_reused, r_out_st, r_out_addr};
    assign w_cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // rounding to MIN_ALIGN (general granule, constant divide)
    assign w_round = {18'd0, s_axis_tdata[32:1]} + (ADDR_W+2)'(MIN_ALIGN - 1);
    assign n_size  = SIZE_W'((w_round / MIN_ALIGN) * MIN_ALIGN);
    assign w_limit = {1'b0, r_base} + (ADDR_W+1)'(r_bytes);

    // oldest-match priority select
    always_comb begin
        w_any   = 1'b0;
        w_idx   = '0;
        w_haddr = '0;
        for (int k = FREE_ENTRIES - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_any   = 1'b1;
                w_idx   = IDX_W'(k);
                w_haddr = w_caddr[k];
            end
        end
    end

    assign w_rm_go  = (r_state == S_BUMP) && r_found;
    assign w_app_go = (r_state == S_BUMP) && (r_op == OP_FREE) && (r_size != '0)
                      && !({1'b0, r_fa} < {1'b0, r_base}) && !(w_fend > {1'b0, w_limit})
                      && (r_count < CNT_W'(FREE_ENTRIES));
    assign w_fend   = {2'b0, r_fa} + (ADDR_W+2)'(r_size);

    always_comb begin
        w_ctl        = '0;
        w_ctl.clear  = w_cfg_wr && (i_cfg_index == REG_HEAP_BASE);
        w_ctl.remove = w_rm_go;
        w_ctl.append = w_app_go;
        w_ctl.size   = r_size;
        w_ctl.addr   = r_fa;
        w_ctl.align  = r_align;
    end

    always_comb begin
        for (int k = 0; k < FREE_ENTRIES; k++)
            w_rm[k] = (IDX_W'(k) >= r_hit_idx);
    end

    for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
        logic              w_nv;
        logic [SIZE_W-1:0] w_ns;
        logic [ADDR_W-1:0] w_na;
        if (g == FREE_ENTRIES - 1) begin : g_end
            assign w_nv = 1'b0;
            assign w_ns = '0;
            assign w_na = '0;
        end else begin : g_mid
            assign w_nv = w_valid[g+1];
            assign w_ns = w_csize[g+1];
            assign w_na = w_caddr[g+1];
        end
        bafl_cell u_cell (
            .i_clk                (i_clk),
            .i_rst_n              (i_rst_n),
            .i_ctl                (w_ctl),
            .i_is_tail            (r_count == CNT_W'(g)),
            .i_remove_here_or_left(w_rm[g]),
            .i_nb_valid           (w_nv),
            .i_nb_size            (w_ns),
            .i_nb_addr            (w_na),
            .o_valid              (w_valid[g]),
            .o_size               (w_csize[g]),
            .o_addr               (w_caddr[g]),
            .o_match              (w_match[g])
        );
    end

    always_comb begin
        w_eff = (ADDR_W+1)'(1) << r_align;
        if (w_eff < (ADDR_W+1)'(MIN_ALIGN)) w_eff = (ADDR_W+1)'(MIN_ALIGN);
    end
    // alignment is a power of two unless MIN_ALIGN is not; constant-divide form
    always_comb begin
        if (w_eff == (ADDR_W+1)'(MIN_ALIGN))
            w_st = (({2'b0, r_next} + (ADDR_W+2)'(MIN_ALIGN - 1)) / MIN_ALIGN) * MIN_ALIGN;
        else
            w_st = ({2'b0, r_next} + {1'b0, w_eff} - (ADDR_W+2)'(1))
                   & ~({1'b0, w_eff} - (ADDR_W+2)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= HEAP_BASE_RST;
            r_bytes <= HEAP_BYTES_RST;
            r_next  <= HEAP_BASE_RST;
            r_count <= '0;
        end else begin
            if (w_cfg_wr) begin
                if (i_cfg_index == REG_HEAP_BASE) begin
                    r_base  <= i_cfg_data;
                    r_next  <= i_cfg_data;
                    r_count <= '0;
                end else begin
                    r_bytes <= i_cfg_data[SIZE_W-1:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= s_axis_tdata[0];
                        r_size  <= n_size;
                        r_align <= s_axis_tdata[36:33];
                        r_fa    <= s_axis_tdata[84:37];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_found    <= w_any && (r_op == OP_ALLOC) && (r_size != '0);
                    r_hit_idx  <= w_idx;
                    r_hit_addr <= w_haddr;
                    r_start    <= w_st[ADDR_W-1:0];
                    r_end      <= w_st[ADDR_W+1] ? {1'b1, {ADDR_W{1'b1}}}
                                  : w_st[ADDR_W:0] + (ADDR_W+1)'(r_size);
                    r_state    <= S_BUMP;
                end
                S_BUMP: begin
                    if (r_size == '0) begin
                        r_out_addr   <= '0;
                        r_out_st     <= ST_ZERO_SIZE;
                        r_out_reused <= 1'b0;
                    end else if (r_op == OP_ALLOC) begin
                        if (r_found) begin
                            r_out_addr   <= r_hit_addr;
                            r_out_st     <= ST_OK;
                            r_out_reused <= 1'b1;
                            r_count      <= r_count - CNT_W'(1);
                        end else if (r_end > w_limit || r_end[ADDR_W]) begin
                            r_out_addr   <= '0;
                            r_out_st     <= ST_NO_MEM;
                            r_out_reused <= 1'b0;
                        end else begin
                            r_out_addr   <= r_start;
                            r_out_st     <= ST_OK;
                            r_out_reused <= 1'b0;
                            r_next       <= r_end[ADDR_W-1:0];
                        end
                    end else if ({1'b0, r_fa} < {1'b0, r_base}
                                 || w_fend > {1'b0, w_limit}) begin
                        r_out_addr   <= '0;
                        r_out_st     <= ST_BAD_FREE;
                        r_out_reused <= 1'b0;
                    end else if (r_count >= CNT_W'(FREE_ENTRIES)) begin
                        r_out_addr   <= '0;
                        r_out_st     <= ST_LIST_FULL;
                        r_out_reused <= 1'b0;
                    end else begin
                        r_out_addr   <= '0;
                        r_out_st     <= ST_OK;
                        r_out_reused <= 1'b0;
                        r_count      <= r_count + CNT_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "bump_allocator_with_free_list_macros.svh"
    `BA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(FREE_ENTRIES))
    `BA_ASSERT(a_valid_eq_count, i_clk, i_rst_n, $countones(w_valid) == int'(r_count))
    `BA_ASSERT(a_found_match, i_clk, i_rst_n, (r_state == S_BUMP && r_found) |-> w_valid[r_hit_idx])
    `BA_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
endmodule
`default_nettype wire

@@ sim/alloc_checker.sv @@
`timescale 1ns / 1ps
module alloc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import bafl_pkg::*;

    localparam int FREE_ENTRIES = 64;
    localparam int GRANULE      = 16;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [2:0]        status;
        logic              reused;
    } t_alloc_result;

    logic [ADDR_W-1:0] base_q;
    logic [SIZE_W-1:0] bytes_q;
    logic [ADDR_W-1:0] bump_q;
    logic [SIZE_W-1:0] fl_size [$];
    logic [ADDR_W-1:0] fl_addr [$];
    t_alloc_result     expected_results [$];

    assign o_pending = expected_results.size();

    function automatic t_alloc_result model_request(input logic [87:0] d);
        logic              op;
        logic [63:0]       sz, al, fa, lim, eff, start, stop;
        t_alloc_result     r;
        bit                hit;
        op  = d[0];
        sz  = ((64'(d[32:1]) + GRANULE - 1) / GRANULE) * GRANULE;
        al  = 64'(d[36:33]);
        fa  = 64'(d[84:37]);
        lim = 64'(base_q) + 64'(bytes_q);
        r   = '0;
        hit = 0;
        if (sz == 0) begin
            r.status = ST_ZERO_SIZE;
        end else if (op == OP_ALLOC) begin
            // oldest exact-size entry meeting the alignment wins
            for (int i = 0; i < fl_size.size(); i++) begin
                if (!hit && 64'(fl_size[i]) == sz &&
                    (64'(fl_addr[i]) & ((64'd1 << al) - 1)) == 0) begin
                    r.addr = fl_addr[i];
                    r.reused = 1'b1;
                    fl_size.delete(i);
                    fl_addr.delete(i);
                    hit = 1;
                end
            end
            if (!hit) begin
                eff = (64'd1 << al);
                if (eff < GRANULE) eff = GRANULE;
                start = ((64'(bump_q) + eff - 1) / eff) * eff;
                stop  = start + sz;
                if (stop > lim || stop > 64'hFFFF_FFFF_FFFF) begin
                    r.status = ST_NO_MEM;
                end else begin
                    r.addr = start[ADDR_W-1:0];
                    bump_q = stop[ADDR_W-1:0];
                end
            end
        end else begin
            if (fa < 64'(base_q) || fa + sz > lim) begin
                r.status = ST_BAD_FREE;
            end else if (fl_size.size() >= FREE_ENTRIES) begin
                r.status = ST_LIST_FULL;
            end else begin
                fl_size = {fl_size, sz[SIZE_W-1:0]};
                fl_addr = {fl_addr, fa[ADDR_W-1:0]};
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result exp_r, got, pred;
        if (!i_rst_n) begin
            base_q  = HEAP_BASE_RST;
            bytes_q = HEAP_BYTES_RST;
            bump_q  = HEAP_BASE_RST;
            fl_size.delete();
            fl_addr.delete();
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_HEAP_BASE) begin
                    base_q = i_cfg_data;
                    bump_q = i_cfg_data;
                    fl_size.delete();
                    fl_addr.delete();
                end else begin
                    bytes_q = i_cfg_data[SIZE_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pred = model_request(s_axis_tdata);
                expected_results = {expected_results, pred};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[47:0], m_axis_tdata[50:48], m_axis_tdata[51]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== got) begin
                        $display("%0t: mismatch expected addr %h st %0d reuse %0d,",
                                 $time, exp_r.addr, exp_r.status, exp_r.reused,
                                 " got addr %h st %0d reuse %0d",
                                 got.addr, got.status, got.reused);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import bafl_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = REG_HEAP_BASE;
    logic [47:0] i_cfg_data = '0;
    int          errors, pending;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    bit          hold_off = 0;
    longint      cycles = 0;
    logic [47:0] cur_base = HEAP_BASE_RST;
    logic [47:0] recent_addr [$];

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    bump_allocator_with_free_list dut (.*);

    alloc_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // remember handed-out addresses so frees can return them
    always @(posedge i_clk)
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[50:48] == ST_OK &&
            m_axis_tdata[47:0] != 0) begin
            recent_addr = {recent_addr, m_axis_tdata[47:0]};
            if (recent_addr.size() > 32) void'(recent_addr.pop_front());
        end

    always @(negedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(input logic op, input logic [31:0] sz, input logic [3:0] al,
                        input logic [47:0] fa);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tdata  = {3'b0, fa, al, sz, op};
        s_axis_tvalid = 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [47:0] val);
        drain();
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        if (idx == REG_HEAP_BASE) begin
            cur_base = val;
            recent_addr.delete();
        end
    endtask

    task automatic random_item;
        logic [31:0] sz;
        logic [47:0] fa;
        int          k;
        k = $urandom_range(99);
        case ($urandom_range(5))
            0, 1, 2: sz = $urandom_range(300);
            3:       sz = 32'd16 * $urandom_range(4);
            4:       sz = $urandom;
            default: sz = $urandom_range(4096);
        endcase
        if (k < 50) begin
            send(OP_ALLOC, sz, 4'($urandom_range(15)), 48'({$urandom, $urandom}));
        end else begin
            if (k < 85 && recent_addr.size() != 0)
                fa = recent_addr[$urandom_range(recent_addr.size() - 1)];
            else if (k < 93)
                fa = cur_base + $urandom_range(65536);
            else
                fa = 48'({$urandom, $urandom});
            if ($urandom_range(1)) sz = 32'd16 * $urandom_range(4);
            send(OP_FREE, sz, 4'($urandom), fa);
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: zero size, extremes, reuse, alignment, bad frees
        send(OP_ALLOC, 32'd0, 4'd0, '0);
        send(OP_FREE, 32'd0, 4'd0, HEAP_BASE_RST);
        send(OP_ALLOC, 32'd1, 4'd0, '1);
        send(OP_ALLOC, 32'd100, 4'd15, '0);
        send(OP_ALLOC, 32'hFFFF_FFFF, 4'd0, '0);
        send(OP_ALLOC, 32'hFFFF_FFF0, 4'd12, '0);
        send(OP_FREE, 32'd16, 4'd0, HEAP_BASE_RST);
        send(OP_ALLOC, 32'd16, 4'd4, '0);
        send(OP_FREE, 32'd32, 4'hF, HEAP_BASE_RST + 48'h1000);
        send(OP_ALLOC, 32'd32, 4'd13, '0);
        send(OP_ALLOC, 32'd32, 4'd12, '0);
        send(OP_FREE, 32'd16, 4'd0, HEAP_BASE_RST - 1);
        send(OP_FREE, 32'hFFFF_FFFF, 4'd0, '1);
        send(OP_FREE, 32'd16, 4'd0, HEAP_BASE_RST + 48'hFFFF_FFF0);
        send(OP_FREE, 32'd32, 4'd0, HEAP_BASE_RST + 48'hFFFF_FFF0);
        // fill the free list past its depth
        for (int i = 0; i < 66; i++)
            send(OP_FREE, 32'd48, 4'd0, HEAP_BASE_RST + 48'h100 * i);

        // heap near the top of the address space: overflow check
        write_reg(REG_HEAP_BASE, 48'hFFFF_FFFF_F000);
        write_reg(REG_HEAP_BYTES, 48'h1_FFFF_FFFF);
        send(OP_ALLOC, 32'h800, 4'd0, '0);
        send(OP_ALLOC, 32'h1000, 4'd0, '0);
        send(OP_FREE, 32'd16, 4'd0, 48'hFFFF_FFFF_F000);

        write_reg(REG_HEAP_BYTES, '0);
        send(OP_ALLOC, 32'd16, 4'd0, '0);
        write_reg(REG_HEAP_BASE, '0);
        write_reg(REG_HEAP_BYTES, 48'h1_0000);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if (ph == 4) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 150; n++) random_item();
            drain();
            case (ph)
                0: write_reg(REG_HEAP_BYTES, 48'h1_0000_0000);
                1: write_reg(REG_HEAP_BASE, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FF00);
                2: write_reg(REG_HEAP_BYTES, 48'h800);
                3: write_reg(REG_HEAP_BASE, 48'h0600_0000_0000);
                4: write_reg(REG_HEAP_BYTES, 48'h1_FFFF_FFFF);
                default: ;
            endcase
        end

        recv_stall_pct = 0;
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+design
design/bafl_pkg.sv
design/bafl_cell.sv
design/bump_allocator_with_free_list.sv
sim/alloc_checker.sv
sim/testbench.sv
